/* hw/rtl/reply_frame_angle_parser_defines.svh */
// Assertion macros for the reply frame angle parser.
// Included by the top level; no other dependencies.
`ifndef REPLY_FRAME_ANGLE_PARSER_DEFINES_SVH
`define REPLY_FRAME_ANGLE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RFAP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rfap check failed");

// Next-cycle implication, disabled while in reset.
`define RFAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rfap check failed");

`endif

/* hw/rtl/rfap_pkg.sv */
// Shared types and constants for the reply frame angle parser.
// No dependencies.
package rfap_pkg;

  localparam logic [7:0]  FRAME_START = 8'h3E;
  localparam logic [7:0]  CMD_RESET   = 8'h94;
  // 360 degrees * 900 counts: positions at or above this are out of range
  localparam logic [31:0] INR_LIMIT   = 32'd324000;
  // floor(q / 225) == (q * DIV_RECIP) >> DIV_SHIFT for q < 81000
  localparam logic [17:0] DIV_RECIP   = 18'd149131;
  localparam int          DIV_SHIFT   = 25;
  localparam logic [8:0]  HALF_TURN   = 9'd180;
  localparam logic [9:0]  FULL_TURN   = 10'd360;

  typedef enum logic [9:0] {
    PH_HUNT = 10'b00_0000_0001,
    PH_CMD  = 10'b00_0000_0010,
    PH_HDR2 = 10'b00_0000_0100,
    PH_HDR3 = 10'b00_0000_1000,
    PH_HSUM = 10'b00_0001_0000,
    PH_D0   = 10'b00_0010_0000,
    PH_D1   = 10'b00_0100_0000,
    PH_D2   = 10'b00_1000_0000,
    PH_D3   = 10'b01_0000_0000,
    PH_DSUM = 10'b10_0000_0000
  } phase_t;

  // Good frame leaving the parser.
  typedef struct packed {
    logic        vld;
    logic [31:0] pos;
    logic        inr;
  } frame_t;

  // Frame with its whole-degree count.
  typedef struct packed {
    logic        vld;
    logic [31:0] pos;
    logic        inr;
    logic [8:0]  deg;
  } deg_t;

endpackage

/* hw/rtl/rfap_frame_fsm.sv */
// Byte-level frame hunter: header match, checksums, position assembly.
// Depends on rfap_pkg.
module rfap_frame_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              byte_acc,
  input  logic [7:0]        rx_byte,
  output rfap_pkg::frame_t  frm
);

  rfap_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  cmd_r;
  logic [7:0]  hsum_r, hsum_nxt;
  logic [7:0]  dsum_r, dsum_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        good;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= rfap_pkg::CMD_RESET;
      phase_r <= rfap_pkg::PH_HUNT;
    end else begin
      if (cfg_wr_en) begin
        cmd_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hsum_r <= hsum_nxt;
    dsum_r <= dsum_nxt;
    pos_r  <= pos_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    hsum_nxt  = hsum_r;
    dsum_nxt  = dsum_r;
    pos_nxt   = pos_r;
    good      = 1'b0;
    if (byte_acc) begin
      unique case (phase_r)
        rfap_pkg::PH_CMD: begin
          if (rx_byte == cmd_r) begin
            hsum_nxt  = hsum_r + rx_byte;
            phase_nxt = rfap_pkg::PH_HDR2;
          end else begin
            // wrong command byte: retest it as a frame start
            hsum_nxt  = rx_byte;
            phase_nxt = (rx_byte == rfap_pkg::FRAME_START) ? rfap_pkg::PH_CMD
                                                          : rfap_pkg::PH_HUNT;
          end
        end
        rfap_pkg::PH_HDR2: begin
          hsum_nxt  = hsum_r + rx_byte;
          phase_nxt = rfap_pkg::PH_HDR3;
        end
        rfap_pkg::PH_HDR3: begin
          hsum_nxt  = hsum_r + rx_byte;
          phase_nxt = rfap_pkg::PH_HSUM;
        end
        rfap_pkg::PH_HSUM: begin
          dsum_nxt  = '0;
          pos_nxt   = '0;
          phase_nxt = (rx_byte == hsum_r) ? rfap_pkg::PH_D0 : rfap_pkg::PH_HUNT;
        end
        rfap_pkg::PH_D0: begin
          dsum_nxt  = dsum_r + rx_byte;
          pos_nxt   = {rx_byte, pos_r[31:8]};
          phase_nxt = rfap_pkg::PH_D1;
        end
        rfap_pkg::PH_D1: begin
          dsum_nxt  = dsum_r + rx_byte;
          pos_nxt   = {rx_byte, pos_r[31:8]};
          phase_nxt = rfap_pkg::PH_D2;
        end
        rfap_pkg::PH_D2: begin
          dsum_nxt  = dsum_r + rx_byte;
          pos_nxt   = {rx_byte, pos_r[31:8]};
          phase_nxt = rfap_pkg::PH_D3;
        end
        rfap_pkg::PH_D3: begin
          dsum_nxt  = dsum_r + rx_byte;
          pos_nxt   = {rx_byte, pos_r[31:8]};
          phase_nxt = rfap_pkg::PH_DSUM;
        end
        rfap_pkg::PH_DSUM: begin
          good      = (rx_byte == dsum_r);
          phase_nxt = rfap_pkg::PH_HUNT;
        end
        default: begin
          hsum_nxt  = rx_byte;
          phase_nxt = (rx_byte == rfap_pkg::FRAME_START) ? rfap_pkg::PH_CMD
                                                        : rfap_pkg::PH_HUNT;
        end
      endcase
    end
  end

  assign frm.vld = good;
  assign frm.pos = pos_r;
  assign frm.inr = (pos_r < rfap_pkg::INR_LIMIT);

endmodule

/* hw/rtl/rfap_deg_div.sv */
// Two-stage divide of the position count by 900 (shift, then reciprocal).
// Depends on rfap_pkg.
module rfap_deg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  rfap_pkg::frame_t  frm,
  output logic              s1_adv,
  output logic              s1_vld,
  output rfap_pkg::deg_t    dq
);

  logic        s1_vld_r;
  logic [31:0] s1_pos_r;
  logic        s1_inr_r;
  logic        s2_vld_r;
  logic [31:0] s2_pos_r;
  logic        s2_inr_r;
  logic [8:0]  s2_deg_r;
  logic        s2_adv;
  logic [16:0] quarter;
  logic [34:0] prod;

  // a stage loads when it is empty or its contents move on
  assign s2_adv = !s2_vld_r || adv;
  assign s1_adv = !s1_vld_r || s2_adv;

  // position < 324000 when in range, so bits 18:2 hold pos/4 exactly
  assign quarter = s1_pos_r[18:2];
  assign prod    = {18'd0, quarter} * {17'd0, rfap_pkg::DIV_RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_vld_r <= frm.vld;
      end
      if (s2_adv) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_pos_r <= frm.pos;
      s1_inr_r <= frm.inr;
    end
    if (s2_adv) begin
      s2_pos_r <= s1_pos_r;
      s2_inr_r <= s1_inr_r;
      s2_deg_r <= prod[rfap_pkg::DIV_SHIFT +: 9];
    end
  end

  assign s1_vld = s1_vld_r;
  assign dq.vld = s2_vld_r;
  assign dq.pos = s2_pos_r;
  assign dq.inr = s2_inr_r;
  assign dq.deg = s2_deg_r;

endmodule

/* hw/rtl/rfap_angle_map.sv */
// Degree-to-angle mapping, held angle and the result register.
// Depends on rfap_pkg.
module rfap_angle_map (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  rfap_pkg::deg_t    dq,
  output logic              out_valid,
  output logic [31:0]       out_raw_position,
  output logic signed [8:0] out_angle_deg,
  output logic              out_in_range,
  output logic signed [8:0] held_angle
);

  logic              vld_r;
  logic [31:0]       pos_r;
  logic signed [8:0] ang_r;
  logic              inr_r;
  logic signed [8:0] held_r, held_nxt;
  logic [8:0]        mapped;

  always_comb begin
    if (dq.deg <= rfap_pkg::HALF_TURN) begin
      mapped = 9'd0 - dq.deg;
    end else begin
      mapped = 9'(rfap_pkg::FULL_TURN - {1'b0, dq.deg});
    end
    held_nxt = (dq.vld && dq.inr) ? $signed(mapped) : held_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      held_r <= '0;
    end else if (adv) begin
      vld_r  <= dq.vld;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r <= dq.pos;
      ang_r <= held_nxt;
      inr_r <= dq.inr;
    end
  end

  assign out_valid        = vld_r;
  assign out_raw_position = pos_r;
  assign out_angle_deg    = ang_r;
  assign out_in_range     = inr_r;
  assign held_angle       = held_r;

endmodule

/* hw/rtl/reply_frame_angle_parser.sv */
// Top level of the reply frame angle parser: byte hunter, divide pipe, angle map.
// Depends on rfap_pkg, rfap_frame_fsm, rfap_deg_div, rfap_angle_map and the defines header.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_stall, in_rx_byte                 | in (request of one byte)
//   result  | out_valid, out_stall, out_raw_position,        | out (request per good frame)
//           | out_angle_deg, out_in_range                    |
//   config  | cfg_wr_en, cfg_wr_data (reply command code)    | in
//
// One byte is taken every cycle unless in_stall is high. The edge that takes a good
// frame's data checksum byte loads stage 1; stage 2 (reciprocal multiply by 1/225 on
// pos/4) loads after it and the result register after that, which raises out_valid.
// rst_n is synchronous: parser hunts, held angle is 0, command code is 0x94.
// Each stage moves when the one after it is empty or moving, so in_stall is high only
// while stage 1, stage 2 and the result register all hold frames and out_stall is high.

`include "reply_frame_angle_parser_defines.svh"

module reply_frame_angle_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_raw_position,
  output logic signed [8:0] out_angle_deg,
  output logic              out_in_range
);

  logic              adv;       // result register loads this cycle
  logic              s1_adv;    // stage 1 loads this cycle
  logic              byte_acc;  // input request taken
  rfap_pkg::frame_t  frm;
  rfap_pkg::deg_t    dq;
  logic              s1_vld;
  logic signed [8:0] held_angle;

  // Result register loads unless a finished result sits unclaimed.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !s1_adv;
  assign byte_acc = in_valid && s1_adv;

  rfap_frame_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_acc    (byte_acc),
    .rx_byte     (in_rx_byte),
    .frm         (frm)
  );

  rfap_deg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .frm    (frm),
    .s1_adv (s1_adv),
    .s1_vld (s1_vld),
    .dq     (dq)
  );

  rfap_angle_map u_map (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .dq               (dq),
    .out_valid        (out_valid),
    .out_raw_position (out_raw_position),
    .out_angle_deg    (out_angle_deg),
    .out_in_range     (out_in_range),
    .held_angle       (held_angle)
  );

  // A good frame always enters stage 1.
  `RFAP_ASSERT_NEXT(a_frame_enters, clk, rst_n, frm.vld && byte_acc, s1_vld)
  // A new result comes only from stage 2.
  `RFAP_ASSERT_NOW(a_out_from_s2, clk, rst_n, $rose(out_valid), $past(dq.vld))
  // The reported angle is the held angle.
  `RFAP_ASSERT_NOW(a_out_is_held, clk, rst_n, out_valid, out_angle_deg == held_angle)
  // Angle stays within a half turn either way.
  `RFAP_ASSERT_NOW(a_angle_span, clk, rst_n, out_valid,
                   out_angle_deg >= -9'sd180 && out_angle_deg <= 9'sd179)

endmodule

/* bench/tb.sv */
// Self-checking bench for reply_frame_angle_parser: byte stream in, one result per good frame.
// Depends on rfap_pkg and the RTL top level; holds its own frame parser model and result queue.

module tb;

  // Fields of one angle result, as the block presents them.
  typedef struct {
    logic [31:0]       pos;
    logic signed [8:0] angle;
    logic              in_range;
  } angle_result_t;

  // Ways a generated frame can be spoiled on purpose.
  typedef enum int {
    FLAW_NONE,
    FLAW_CMD,
    FLAW_HSUM,
    FLAW_DSUM
  } frame_flaw_t;

  // Handshake pressure per traffic phase.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int unsigned COUNTS_PER_DEG = 900;

  // Frame parser model plus the queue of angle results it has predicted.
  class angle_scoreboard;
    logic [7:0]        cmd_code;
    int unsigned       phase;      // index of the next expected frame byte, 0 = hunting
    logic [7:0]        hdr_sum;
    logic [7:0]        dat_sum;
    logic [31:0]       pos_acc;
    logic signed [8:0] held_angle;
    angle_result_t     pending_angles[$];
    int unsigned       fails;

    function new();
      cmd_code   = rfap_pkg::CMD_RESET;
      phase      = 0;
      hdr_sum    = '0;
      dat_sum    = '0;
      pos_acc    = '0;
      held_angle = '0;
      fails      = 0;
    endfunction

    task report(string what);
      fails++;
      $display("ERROR @%0t: %s", $time, what);
    endtask

    // Clear the running sums; the byte itself may open a new frame.
    function void hunt(logic [7:0] b);
      hdr_sum = '0;
      dat_sum = '0;
      pos_acc = '0;
      if (b == rfap_pkg::FRAME_START) begin
        hdr_sum = b;
        phase   = 1;
      end else begin
        phase = 0;
      end
    endfunction

    // One accepted byte request.
    function void note_request(logic [7:0] b);
      int unsigned   deg;
      int            ang;
      angle_result_t r;
      case (phase)
        0: hunt(b);
        1: begin
          if (b == cmd_code) begin
            hdr_sum = hdr_sum + b;
            phase   = 2;
          end else begin
            hunt(b);
          end
        end
        2, 3: begin
          hdr_sum = hdr_sum + b;
          phase++;
        end
        4: begin
          if (b == hdr_sum) begin
            dat_sum = '0;
            pos_acc = '0;
            phase   = 5;
          end else begin
            // rejected header: hunting resumes on the next byte
            phase   = 0;
            hdr_sum = '0;
          end
        end
        5, 6, 7, 8: begin
          dat_sum = dat_sum + b;
          pos_acc = {b, pos_acc[31:8]};
          phase++;
        end
        default: begin
          // data checksum byte ends the frame either way
          phase   = 0;
          hdr_sum = '0;
          if (b == dat_sum) begin
            deg        = pos_acc / COUNTS_PER_DEG;
            r.in_range = 1'b1;
            if (deg <= rfap_pkg::HALF_TURN) begin
              ang        = -int'(deg);
              held_angle = ang[8:0];
            end else if (deg < rfap_pkg::FULL_TURN) begin
              ang        = int'(rfap_pkg::FULL_TURN) - int'(deg);
              held_angle = ang[8:0];
            end else begin
              r.in_range = 1'b0;
            end
            r.pos   = pos_acc;
            r.angle = held_angle;
            pending_angles.insert(pending_angles.size(), r);
          end
          dat_sum = '0;
        end
      endcase
    endfunction

    task check_result(logic [31:0] pos, logic signed [8:0] angle, logic inr);
      angle_result_t exp_r;
      if (pending_angles.size() == 0) begin
        report($sformatf("unexpected result pos=%h angle=%0d", pos, angle));
      end else begin
        exp_r = pending_angles.pop_front();
        if (pos !== exp_r.pos)
          report($sformatf("raw_position %h, want %h", pos, exp_r.pos));
        if (angle !== exp_r.angle)
          report($sformatf("angle_deg %0d, want %0d (pos %h)", angle, exp_r.angle, exp_r.pos));
        if (inr !== exp_r.in_range)
          report($sformatf("in_range %b, want %b (pos %h)", inr, exp_r.in_range, exp_r.pos));
      end
    endtask
  endclass

  // Every input known from time zero.
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [7:0]        cfg_wr_data = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte  = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [31:0]       out_raw_position;
  logic signed [8:0] out_angle_deg;
  logic              out_in_range;

  angle_scoreboard sb;
  int unsigned     tx_gap_pct   = 0;
  int unsigned     rx_stall_pct = 0;
  int unsigned     bytes_sent   = 0;

  reply_frame_angle_parser i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_raw_position (out_raw_position),
    .out_angle_deg    (out_angle_deg),
    .out_in_range     (out_in_range)
  );

  // 4-unit period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure: a fresh coin per cycle, off when the phase asks for none.
  always @(posedge clk) begin
    out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
  end

  // Result side: values read here are the ones from just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_raw_position, out_angle_deg, out_in_range);
  end

  // One byte request. Random gaps first, then hold valid and payload until taken.
  // Valid is raised once per request; the gap loop and drain are the only places it drops.
  task automatic send_byte(input logic [7:0] b);
    while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_request(b);
    bytes_sent++;
  endtask

  // Ten-byte reply frame with both checksums, optionally spoiled.
  task automatic send_frame(input logic [7:0] cmd, input logic [31:0] pos,
                            input frame_flaw_t flaw);
    logic [7:0] f[10];
    f[0] = rfap_pkg::FRAME_START;
    f[1] = (flaw == FLAW_CMD) ? (cmd ^ (8'd1 << $urandom_range(7))) : cmd;
    f[2] = 8'($urandom);
    f[3] = 8'($urandom);
    f[4] = f[0] + f[1] + f[2] + f[3];
    f[5] = pos[7:0];
    f[6] = pos[15:8];
    f[7] = pos[23:16];
    f[8] = pos[31:24];
    f[9] = f[5] + f[6] + f[7] + f[8];
    if (flaw == FLAW_HSUM) f[4] = f[4] ^ 8'($urandom_range(255, 1));
    if (flaw == FLAW_DSUM) f[9] = f[9] ^ 8'($urandom_range(255, 1));
    for (int i = 0; i < 10; i++) send_byte(f[i]);
  endtask

  // Counts weighted toward the useful range, with the degree edges hit often.
  function automatic logic [31:0] pick_position();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 32'($urandom_range(323999));
    if (r < 85) begin
      case ($urandom_range(9))
        0:       return 32'd0;
        1:       return 32'd899;
        2:       return 32'd900;
        3:       return 32'd162899;   // last count of 180 degrees
        4:       return 32'd162900;   // first count of 181 degrees
        5:       return 32'd163799;
        6:       return 32'd323099;
        7:       return 32'd323999;   // last in-range count
        8:       return 32'd324000;   // first out-of-range count
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return 32'($urandom);
  endfunction

  // Mostly well-formed frames with random content; the rest is line noise.
  task automatic random_traffic(input int unsigned n);
    int unsigned start;
    int unsigned r;
    frame_flaw_t flaw;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      if ($urandom_range(99) < 70) begin
        r = $urandom_range(99);
        flaw = (r < 80) ? FLAW_NONE : (r < 87) ? FLAW_CMD : (r < 94) ? FLAW_HSUM : FLAW_DSUM;
        send_frame(sb.cmd_code, pick_position(), flaw);
      end else begin
        repeat ($urandom_range(6, 1))
          send_byte(($urandom_range(3) == 0) ? rfap_pkg::FRAME_START : 8'($urandom));
      end
    end
  endtask

  // Let every predicted result out, then cover the parser-to-output pipe
  // in case the last bytes were a dropped frame still in flight.
  task automatic drain();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending_angles.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Command code changes only with the block idle.
  task automatic write_cmd(input logic [7:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.cmd_code = v;
  endtask

  task automatic set_pressure(input idle_mode_t m);
    case (m)
      IDLE_NONE:     begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SENDER:   begin tx_gap_pct = 60; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_gap_pct = 0;  rx_stall_pct = 60; end
      default:       begin tx_gap_pct = 31; rx_stall_pct = 31; end
    endcase
  endtask

  // Hard stop well past the slowest legal run (about 1000 requests).
  initial begin
    #400000;
    $display("reply_frame_angle_parser: mismatch");
    $finish;
  end

  initial begin
    logic [7:0] codes[6];
    sb = new();
    codes[0] = rfap_pkg::CMD_RESET;      // reset value, no write
    codes[1] = 8'h00;
    codes[2] = 8'hFF;
    codes[3] = rfap_pkg::FRAME_START;    // command equal to the start byte
    codes[4] = 8'($urandom);
    codes[5] = rfap_pkg::CMD_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: degree edges, out-of-range counts, frames rejected on either checksum.
    set_pressure(IDLE_NONE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(rfap_pkg::CMD_RESET, 32'd0, FLAW_NONE);
    send_frame(rfap_pkg::CMD_RESET, 32'd162899, FLAW_NONE);   // -180
    send_frame(rfap_pkg::CMD_RESET, 32'd162900, FLAW_NONE);   // 179
    send_frame(rfap_pkg::CMD_RESET, 32'd323999, FLAW_NONE);   // 1
    send_frame(rfap_pkg::CMD_RESET, 32'd324000, FLAW_NONE);   // out of range, angle held
    send_frame(rfap_pkg::CMD_RESET, 32'hFFFF_FFFF, FLAW_NONE);
    send_frame(rfap_pkg::CMD_RESET, 32'd90000, FLAW_DSUM);    // silently dropped
    // start byte where the command belongs: hunt restarts on that byte
    send_byte(rfap_pkg::FRAME_START);
    send_frame(rfap_pkg::CMD_RESET, 32'd900, FLAW_NONE);
    // bad header sum, then a clean frame right behind it
    send_frame(rfap_pkg::CMD_RESET, 32'd1800, FLAW_HSUM);
    send_frame(rfap_pkg::CMD_RESET, 32'd200000, FLAW_NONE);

    // Random phases, each setting a command code and a handshake pressure from its list.
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_cmd(codes[p]);
      set_pressure(idle_mode_t'(p % 4));
      random_traffic(150);
    end

    drain();
    if (sb.pending_angles.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending_angles.size()));

    if (sb.fails == 0) begin
      $display("reply_frame_angle_parser: match");
    end else begin
      $display("reply_frame_angle_parser: mismatch");
    end
    $finish;
  end

endmodule
